/* sv/pfd_pkg.sv */
// ----------------------------------------------------------------------------
// pfd_pkg: shared types and constants for the PCM sample FIFO to DAC block
// Payload structs, operation codes, register map and ring geometry.
// ----------------------------------------------------------------------------
package pfd_pkg;

	// ring geometry
	localparam int RING_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(RING_DEPTH);
	localparam int CNT_W      = ADDR_W + 1;     // counts modulo 2*depth
	localparam int FILL_W     = 11;             // width of the reported level

	// operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// register map (word index)
	localparam logic REG_STEREO  = 1'b0;
	localparam logic REG_DAC_MAX = 1'b1;
	localparam int   PADDR_W     = 3;

	localparam logic [15:0] DAC_MAX_RST = 16'd4095;

	typedef struct packed {
		logic               operation;
		logic signed [15:0] sample;
		logic               channel;
	} pfd_in_t;

	typedef struct packed {
		logic              accepted;
		logic [15:0]       dac_code;
		logic [FILL_W-1:0] fill_level;
	} pfd_out_t;

	// status that rides along with a sample through the converter
	typedef struct packed {
		logic              pop_ok;
		logic              accepted;
		logic [FILL_W-1:0] fill;
	} pfd_ctl_t;

endpackage

/* sv/pcm_fifo_to_dac.sv */
// ----------------------------------------------------------------------------
// pcm_fifo_to_dac: ring FIFO of signed PCM samples with DAC code conversion
// Push stores a sample (right samples dropped in stereo mode), pop converts
// the oldest sample to an offset-binary DAC code clamped to 0..dac_max.
// ----------------------------------------------------------------------------
//
//  channel   | signals                              | direction
//  ----------+--------------------------------------+-----------
//  command   | start, busy, item                    | in
//  result    | done, result                         | out
//  config    | psel, penable, pwrite, paddr, pwdata,| in/out
//            | prdata, pready                       |
//
// One transfer per cycle: busy is never raised, a command is taken whenever
// start is high. Every command yields one result; done pulses once the
// command has passed the ring read register, the multiplier register and
// the result register. The receiver cannot stall the result strobe, so no
// backpressure path exists. Reset clears the ring pointers and loads the
// register defaults; the sample memory is not cleared and needs no
// clearing pass, since a pop only reads entries that were written.
// ----------------------------------------------------------------------------
module pcm_fifo_to_dac (
	input  logic                               clk,
	input  logic                               arst_n,
	// command
	input  logic                               start,
	output logic                               busy,
	input  pfd_pkg::pfd_in_t                   item,
	// result
	output logic                               done,
	output pfd_pkg::pfd_out_t                  result,
	// config
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pfd_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	// config registers
	logic        stereo_q;
	logic [15:0] dac_max_q;
	logic        cfg_wr;

	// ring pointers
	logic [pfd_pkg::CNT_W-1:0] wr_cnt_q;
	logic [pfd_pkg::CNT_W-1:0] rd_cnt_q;
	logic [pfd_pkg::CNT_W-1:0] level;
	logic [pfd_pkg::CNT_W-1:0] level_nxt;
	logic [31:0]               level_ext;
	logic                      full;
	logic                      empty;

	// command decode
	logic                      take;
	logic                      is_push;
	logic                      drop_right;
	logic                      store;
	logic                      pop_ok;
	pfd_pkg::pfd_ctl_t         ctl_nxt;

	// sample memory, read data registered
	logic signed [15:0]        ring_mem [pfd_pkg::RING_DEPTH];
	logic signed [15:0]        rdata_s1;
	pfd_pkg::pfd_ctl_t         ctl_s1;
	logic                      valid_s1;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q  <= 1'b0;
			dac_max_q <= pfd_pkg::DAC_MAX_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				pfd_pkg::REG_STEREO:  stereo_q  <= pwdata[0];
				pfd_pkg::REG_DAC_MAX: dac_max_q <= pwdata[15:0];
				default:              stereo_q  <= stereo_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			pfd_pkg::REG_STEREO:  prdata = {31'd0, stereo_q};
			pfd_pkg::REG_DAC_MAX: prdata = {16'd0, dac_max_q};
			default:              prdata = 32'd0;
		endcase
	end

	// ---------------- command decode ----------------
	assign busy  = 1'b0;
	assign take  = start && !busy;

	// pointers run modulo 2*depth so full and empty differ
	assign level = wr_cnt_q - rd_cnt_q;
	assign full  = (level == pfd_pkg::CNT_W'(pfd_pkg::RING_DEPTH));
	assign empty = (wr_cnt_q == rd_cnt_q);

	always_comb begin
		is_push    = (item.operation == pfd_pkg::OP_PUSH);
		// right sample in stereo mode: consumed, not stored, no full check
		drop_right = is_push && stereo_q && item.channel;
		store      = is_push && !drop_right && !full;
		pop_ok     = !is_push && !empty;
		level_nxt  = level + pfd_pkg::CNT_W'(store) - pfd_pkg::CNT_W'(pop_ok);
		level_ext  = 32'(level_nxt);

		ctl_nxt.pop_ok   = pop_ok;
		ctl_nxt.accepted = drop_right || store || pop_ok;
		ctl_nxt.fill     = level_ext[pfd_pkg::FILL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q <= '0;
			rd_cnt_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
			if (take && store) begin
				wr_cnt_q <= wr_cnt_q + 1'b1;
			end
			if (take && pop_ok) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	// ---------------- sample memory ----------------
	// a pop reads the oldest entry; a push in the same cycle writes a
	// different slot, and a later pop of that slot sees the new data
	always_ff @(posedge clk) begin
		if (take && store) begin
			ring_mem[wr_cnt_q[pfd_pkg::ADDR_W-1:0]] <= item.sample;
		end
		rdata_s1 <= ring_mem[rd_cnt_q[pfd_pkg::ADDR_W-1:0]];
		ctl_s1   <= ctl_nxt;
	end

	// ---------------- conversion ----------------
	pfd_dac_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.ctl_s1    (ctl_s1),
		.sample_s1 (rdata_s1),
		.dac_max   (dac_max_q),
		.done      (done),
		.result    (result)
	);

	// ---------------- checks ----------------
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= pfd_pkg::CNT_W'(pfd_pkg::RING_DEPTH))
		else $error("ring level beyond depth");

	a_push_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(take && store) |=> (wr_cnt_q == $past(wr_cnt_q) + 1'b1))
		else $error("write pointer did not advance on stored push");

	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.accepted) |-> (result.dac_code == 16'd0))
		else $error("refused command carries a DAC code");

endmodule

/* sv/pfd_dac_conv.sv */
// ----------------------------------------------------------------------------
// pfd_dac_conv: signed PCM sample to unsigned DAC code
// Two stages: multiply by the midpoint, then scale, offset and clamp.
// ----------------------------------------------------------------------------
module pfd_dac_conv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  pfd_pkg::pfd_ctl_t   ctl_s1,
	input  logic signed [15:0]  sample_s1,
	input  logic [15:0]         dac_max,
	output logic                done,
	output pfd_pkg::pfd_out_t   result
);

	logic signed [15:0] mid;
	logic signed [31:0] prod_s2;
	pfd_pkg::pfd_ctl_t  ctl_s2;
	logic               valid_s2;

	logic signed [31:0] prod_bias;
	logic signed [31:0] quot;
	logic signed [17:0] code_raw;
	logic [15:0]        code;

	logic               done_q;
	pfd_pkg::pfd_out_t  result_q;

	assign mid = $signed({1'b0, dac_max[15:1]});

	// stage 2: product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= 32'(sample_s1) * 32'(mid);
		ctl_s2  <= ctl_s1;
	end

	// divide by 32768 toward zero: bias negatives before the shift
	always_comb begin
		prod_bias = prod_s2 + (prod_s2[31] ? 32'sd32767 : 32'sd0);
		quot      = prod_bias >>> 15;
		code_raw  = 18'($signed({1'b0, mid})) + quot[17:0];
		if (code_raw < 18'sd0) begin
			code = 16'd0;
		end else if (code_raw > $signed({2'b00, dac_max})) begin
			code = dac_max;
		end else begin
			code = code_raw[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		result_q.accepted   <= ctl_s2.accepted;
		result_q.dac_code   <= ctl_s2.pop_ok ? code : 16'd0;
		result_q.fill_level <= ctl_s2.fill;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* bench/pcm_dac_checker.sv */
// ----------------------------------------------------------------------------
// pcm_dac_checker: result checker for the PCM sample FIFO to DAC block
// Watches the command, result and register channels, keeps its own ring and
// register copy, and compares each result transfer with the oldest due one.
// ----------------------------------------------------------------------------
module pcm_dac_checker
	import pfd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  pfd_in_t             item,
	input  logic                done,
	input  pfd_out_t            result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	input  logic [31:0]         prdata,
	input  logic                pready,
	output int                  mismatches,
	output int                  waiting
);

	localparam logic [PADDR_W-1:0] ADDR_STEREO  = {REG_STEREO, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_DAC_MAX = {REG_DAC_MAX, 2'b00};

	logic [15:0]      ring [RING_DEPTH];
	logic [CNT_W-1:0] wr_cnt;
	logic [CNT_W-1:0] rd_cnt;
	logic             keep_left;
	logic [15:0]      full_scale;
	pfd_out_t         due_results [$];

	// offset-binary code: mid + s*mid/32768, truncated toward zero, clamped
	function automatic logic [15:0] dac_code_of(logic [15:0] raw, logic [15:0] fs);
		int s;
		int mid;
		int y;
		s   = int'($signed(raw));
		mid = int'(fs >> 1);
		y   = mid + (s * mid) / 32768;
		if (y < 0)
			y = 0;
		if (y > int'(fs))
			y = int'(fs);
		return y[15:0];
	endfunction

	// advance the ring copy by one command, return the result it must give
	function automatic pfd_out_t fifo_step(pfd_in_t c);
		pfd_out_t         r;
		logic [CNT_W-1:0] lvl;
		r   = '0;
		lvl = wr_cnt - rd_cnt;
		if (c.operation == OP_PUSH) begin
			if (keep_left && c.channel) begin
				r.accepted = 1'b1;      // right sample dropped, no full check
			end else if (lvl < RING_DEPTH) begin
				ring[wr_cnt[ADDR_W-1:0]] = c.sample;
				wr_cnt = wr_cnt + 1'b1;
				r.accepted = 1'b1;
			end
		end else if (lvl != 0) begin
			r.dac_code = dac_code_of(ring[rd_cnt[ADDR_W-1:0]], full_scale);
			rd_cnt = rd_cnt + 1'b1;
			r.accepted = 1'b1;
		end
		lvl = wr_cnt - rd_cnt;
		r.fill_level = FILL_W'(lvl);
		return r;
	endfunction

	task automatic note_miss(string what, longint unsigned want, longint unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %s: expected %0h, got %0h", what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pfd_out_t    due;
		logic [31:0] reg_val;
		if (!arst_n) begin
			wr_cnt     = '0;
			rd_cnt     = '0;
			keep_left  = 1'b0;
			full_scale = DAC_MAX_RST;
			due_results.delete();
			mismatches = 0;
			waiting    = 0;
		end else begin
			if (done) begin
				if (due_results.size() == 0) begin
					note_miss("result with nothing due", 0, result);
				end else begin
					due = due_results.pop_front();
					if (result.accepted !== due.accepted)
						note_miss("accepted", due.accepted, result.accepted);
					if (result.dac_code !== due.dac_code)
						note_miss("dac_code", due.dac_code, result.dac_code);
					if (result.fill_level !== due.fill_level)
						note_miss("fill_level", due.fill_level, result.fill_level);
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == ADDR_STEREO)
						keep_left = pwdata[0];
					else if (paddr == ADDR_DAC_MAX)
						full_scale = pwdata[15:0];
				end else begin
					reg_val = (paddr == ADDR_DAC_MAX) ? {16'b0, full_scale}
						: {31'b0, keep_left};
					if (prdata !== reg_val)
						note_miss("register read", reg_val, prdata);
				end
			end
			if (start && !busy)
				due_results.push_back(fifo_step(item));
			waiting = due_results.size();
		end
	end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the PCM sample FIFO to DAC block
// Directed corner commands, then randomized phases under several register
// settings; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import pfd_pkg::*;

	// byte addresses of the two registers (word index times four)
	localparam logic [PADDR_W-1:0] ADDR_STEREO  = {REG_STEREO, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_DAC_MAX = {REG_DAC_MAX, 2'b00};

	// worst case is ~1600 commands, each after its longest idle gap, plus
	// register traffic; this is many times that
	localparam int LIMIT = 200000;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	logic               busy;
	pfd_in_t            item    = '0;
	logic               done;
	pfd_out_t           result;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [31:0]        pwdata  = '0;
	logic [31:0]        prdata;
	logic               pready;

	int mismatches;
	int waiting;
	int burst_left = 0;     // commands left in a back-to-back stretch

	pcm_fifo_to_dac u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	pcm_dac_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// hard stop if the block hangs or drops results
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	function automatic pfd_in_t cmd(logic op, logic signed [15:0] smp, logic ch);
		pfd_in_t c;
		c.operation = op;
		c.sample    = smp;
		c.channel   = ch;
		return c;
	endfunction

	// random command; the sample leans on the extremes now and then, and
	// pops carry random sample and channel bits since both are ignored there
	function automatic pfd_in_t rand_cmd(int push_pct);
		pfd_in_t c;
		c.operation = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
		case ($urandom_range(15))
			0: c.sample = 16'sh7fff;
			1: c.sample = 16'sh8000;
			2: c.sample = 16'sh0000;
			3: c.sample = 16'shffff;
			default: c.sample = 16'($urandom);
		endcase
		c.channel = 1'($urandom_range(1));
		return c;
	endfunction

	// one command transfer. A random idle gap, possibly empty, goes first
	// unless a back-to-back stretch runs; with no gap, start stays high.
	task automatic send_cmd(pfd_in_t c);
		int gap;
		gap = (burst_left > 0) ? 0 : $urandom_range(14);
		if (burst_left > 0)
			burst_left--;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= c;
		do @(posedge clk); while (busy);
	endtask

	// stop sending and hold off until every due result has come back;
	// the level is looked at on the falling edge, clear of the checker update
	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (waiting != 0);
		@(posedge clk);
	endtask

	// APB transfers: setup, access, hold until pready, then back to idle
	task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// read-back value is checked by the checker
	task automatic reg_read(logic [PADDR_W-1:0] addr);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only with the block drained
	task automatic set_mode(logic stereo, logic [15:0] fs);
		wait_drained();
		reg_write(ADDR_STEREO, {31'b0, stereo});
		reg_read(ADDR_STEREO);
		reg_write(ADDR_DAC_MAX, {16'b0, fs});
		reg_read(ADDR_DAC_MAX);
	endtask

	// random phase; pause_at (if in range) drains the block mid-phase
	task automatic run_phase(int count, int push_pct, int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				wait_drained();
			if (burst_left == 0 && $urandom_range(19) == 0)
				burst_left = $urandom_range(10, 60);
			send_cmd(rand_cmd(push_pct));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: mono, full scale 4095; read both back first
		reg_read(ADDR_STEREO);
		reg_read(ADDR_DAC_MAX);

		// pop from an empty ring, then the sample extremes in mono mode
		// (a right-tagged sample is still stored here)
		send_cmd(cmd(OP_POP,  16'sh1234, 1'b1));
		send_cmd(cmd(OP_PUSH, 16'sh7fff, 1'b0));
		send_cmd(cmd(OP_PUSH, 16'sh8000, 1'b1));
		send_cmd(cmd(OP_PUSH, 16'sh0000, 1'b0));
		send_cmd(cmd(OP_PUSH, 16'shffff, 1'b1));
		send_cmd(cmd(OP_PUSH, 16'sh4000, 1'b0));
		repeat (5) send_cmd(cmd(OP_POP, 16'sh7fff, 1'b0));
		send_cmd(cmd(OP_POP, 16'sh8000, 1'b0));

		// stereo with 16-bit full scale: right samples are dropped
		set_mode(1'b1, 16'hffff);
		send_cmd(cmd(OP_PUSH, 16'sh7fff, 1'b0));
		send_cmd(cmd(OP_PUSH, 16'sh8000, 1'b1));
		send_cmd(cmd(OP_PUSH, 16'sh8000, 1'b0));
		repeat (3) send_cmd(cmd(OP_POP, 16'sh0000, 1'b0));

		// zero full scale: every code is 0
		set_mode(1'b0, 16'h0000);
		send_cmd(cmd(OP_PUSH, 16'sh7fff, 1'b0));
		send_cmd(cmd(OP_POP,  16'sh0000, 1'b0));

		// full scale of one, mid is still 0
		set_mode(1'b1, 16'h0001);
		send_cmd(cmd(OP_PUSH, 16'sh8000, 1'b0));
		send_cmd(cmd(OP_POP,  16'sh0000, 1'b1));

		// random phases under a spread of settings
		set_mode(1'b0, 16'hffff);
		run_phase(150, 50, 75);

		// push-heavy mono run: fills the ring and keeps knocking on it full
		set_mode(1'b0, 16'($urandom_range(1, 65535)));
		run_phase(1150, 98, 600);

		// stereo while near full: right pushes still go through; mostly drains
		set_mode(1'b1, 16'h0001);
		run_phase(100, 30, -1);

		set_mode(1'b0, 16'h0000);
		run_phase(60, 50, -1);

		set_mode(1'b1, 16'($urandom_range(1, 65535)));
		run_phase(90, 45, -1);

		// let the last results land and catch any stray strobe
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && waiting == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/pfd_pkg.sv
sv/pfd_dac_conv.sv
sv/pcm_fifo_to_dac.sv
bench/pcm_dac_checker.sv
bench/testbench.sv
